/* src/sat_pkg.sv */
// Package for the sample address tally block.
// Holds shared constants and the sequencer state type; no dependencies.
`default_nettype none
package sat_pkg;
  localparam int unsigned TableSlotsDef = 4096;
  localparam int unsigned DepthLimitDef = 32;
  localparam logic [31:0] HashMult      = 32'd2654435761;
  localparam logic [5:0]  MaxDepthReset = 6'd8;
  localparam logic        OpRecord      = 1'b0;
  localparam logic        OpRead        = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE_REQ,
    ST_PROBE_CHK,
    ST_DUP_SCAN,
    ST_READ_REQ,
    ST_READ_WAIT,
    ST_OUT
  } sat_state_e;
endpackage
`default_nettype wire

/* src/sample_address_tally.sv */
// Sample address tally: hashes sampled frame addresses into a leaf table and
// an inclusive table, each using multiplicative hashing with linear probing.
// After reset a clearing pass writes zero to every slot of both tables, one
// slot per cycle, during which no item is accepted. A read item passes through
// a read request state, a read wait state and the output state before the next
// acceptance. A record item passes through the accepting state, a hash state,
// a request state and a check state per probe through the single memory port of
// each table, a duplicate scan of one stored frame per cycle over the current
// sample, and an output state that holds until its result beat is taken; probe
// walks on crowded tables set the worst case. Depends on sat_pkg.
`default_nettype none
module sample_address_tally #(
  parameter int unsigned TABLE_SLOTS = sat_pkg::TableSlotsDef,
  parameter int unsigned DEPTH_LIMIT = sat_pkg::DepthLimitDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // cfg: max_depth [5:0]
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [5:0]    cfg_data_i,
  // tdata: op[0], frame_addr[64:1], table_select[65], slot_index[77:66], pad to 80
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [79:0]   s_axis_tdata,
  // tuser: first_frame
  input  wire logic          s_axis_tuser,
  // tdata: rd_addr[63:0], rd_count[95:64], leaf_in_use[108:96],
  //        incl_in_use[121:109], sample_total[153:122], pad to 160
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [159:0]       m_axis_tdata,
  // tuser: dropped
  output logic               m_axis_tuser
);
  import sat_pkg::*;

  localparam int unsigned SlotW  = $clog2(TABLE_SLOTS);
  localparam int unsigned DepthW = $clog2(DEPTH_LIMIT + 1);
  localparam int unsigned FrW    = (DEPTH_LIMIT > 1) ? $clog2(DEPTH_LIMIT) : 1;
  localparam int unsigned CntW   = SlotW + 1;

  // Memories.
  logic [63:0] leaf_keys [TABLE_SLOTS];
  logic [31:0] leaf_cnts [TABLE_SLOTS];
  logic [63:0] incl_keys [TABLE_SLOTS];
  logic [31:0] incl_cnts [TABLE_SLOTS];
  logic [63:0] frames    [DEPTH_LIMIT];

  sat_state_e  state_q, state_d;
  logic [5:0]  max_depth_q;
  logic [SlotW-1:0] clr_q;
  logic        op_q, sel_q, first_q;
  logic [63:0] addr_q;
  logic [11:0] idx_q;
  logic [CntW-1:0] leaf_occ_q, incl_occ_q;
  logic [31:0] samples_q;
  logic [DepthW-1:0] pos_q;
  logic [DepthW-1:0] scan_q;
  logic        dup_q, drop_q;
  logic        tbl_q;     // 0 probing leaf, 1 probing inclusive
  logic [SlotW-1:0] ppos_q;
  logic [CntW-1:0]  pn_q;
  logic [63:0] rk_q;
  logic [31:0] rc_q;
  logic [63:0] ra_q;
  logic [31:0] rcnt_q;
  logic [63:0] frd_q;
  logic        frd_v_q;

  logic [SlotW-1:0] hash_slot;
  logic [DepthW-1:0] depth_eff;
  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;
  // Only the low slot bits of the product are needed, and they depend only on
  // the low slot bits of both factors.
  assign hash_slot = SlotW'(addr_q[SlotW+1:2] * HashMult[SlotW-1:0]);

  // Effective depth clamp.
  always_comb begin
    if (max_depth_q == 6'd0) depth_eff = DepthW'(1);
    else if (32'(max_depth_q) > DEPTH_LIMIT) depth_eff = DepthW'(DEPTH_LIMIT);
    else depth_eff = DepthW'(max_depth_q);
  end

  logic take_incl;
  assign take_incl = pos_q < depth_eff;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == SlotW'(TABLE_SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_fire) begin
        if (s_axis_tdata[0] == OpRead) state_d = ST_READ_REQ;
        else state_d = ST_HASH;
      end
      ST_HASH: begin
        if (first_q) state_d = (addr_q == 64'd0) ? ST_DUP_SCAN : ST_PROBE_REQ;
        else state_d = ST_DUP_SCAN;
      end
      ST_PROBE_REQ: state_d = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (rk_q == addr_q || rk_q == 64'd0 || pn_q == CntW'(TABLE_SLOTS - 1)) begin
          state_d = tbl_q ? ST_OUT : ST_DUP_SCAN;
        end else state_d = ST_PROBE_REQ;
      end
      ST_DUP_SCAN: begin
        if (!take_incl) state_d = ST_OUT;
        else if (frd_v_q || scan_q < pos_q) state_d = ST_DUP_SCAN;
        else if (dup_q || addr_q == 64'd0) state_d = ST_OUT;
        else state_d = ST_PROBE_REQ;
      end
      ST_READ_REQ:  state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_OUT;
      ST_OUT:       if (out_fire) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
  end

  logic [SlotW-1:0] probe_addr;
  logic [SlotW-1:0] rd_slot;
  assign probe_addr = ppos_q;
  assign rd_slot = SlotW'(idx_q);

  logic hit, empty_slot, last_probe;
  assign hit        = (rk_q == addr_q);
  assign empty_slot = (rk_q == 64'd0);
  assign last_probe = (pn_q == CntW'(TABLE_SLOTS - 1));

  // Memory ports: one access per table per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      leaf_keys[clr_q] <= 64'd0; leaf_cnts[clr_q] <= 32'd0;
      incl_keys[clr_q] <= 64'd0; incl_cnts[clr_q] <= 32'd0;
    end else if (state_q == ST_PROBE_CHK && !tbl_q && (hit || empty_slot)) begin
      leaf_keys[probe_addr] <= addr_q;
      leaf_cnts[probe_addr] <= empty_slot ? 32'd1 : ((rc_q == '1) ? rc_q : rc_q + 32'd1);
    end else if (state_q == ST_PROBE_CHK && tbl_q && (hit || empty_slot)) begin
      incl_keys[probe_addr] <= addr_q;
      incl_cnts[probe_addr] <= empty_slot ? 32'd1 : ((rc_q == '1) ? rc_q : rc_q + 32'd1);
    end
    if (state_q == ST_PROBE_REQ) begin
      rk_q <= tbl_q ? incl_keys[probe_addr] : leaf_keys[probe_addr];
      rc_q <= tbl_q ? incl_cnts[probe_addr] : leaf_cnts[probe_addr];
    end else if (state_q == ST_READ_REQ) begin
      rk_q <= sel_q ? incl_keys[rd_slot] : leaf_keys[rd_slot];
      rc_q <= sel_q ? incl_cnts[rd_slot] : leaf_cnts[rd_slot];
    end
    // Sample frame store: one read per scan cycle, write at the end.
    frd_q <= frames[scan_q[FrW-1:0]];
    if (state_q == ST_DUP_SCAN && take_incl && !frd_v_q && scan_q >= pos_q
        && 32'(pos_q) < DEPTH_LIMIT) begin
      frames[pos_q[FrW-1:0]] <= addr_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; max_depth_q <= MaxDepthReset;
      leaf_occ_q <= '0; incl_occ_q <= '0; samples_q <= '0; pos_q <= '0;
      scan_q <= '0; dup_q <= 1'b0; drop_q <= 1'b0; tbl_q <= 1'b0;
      ppos_q <= '0; pn_q <= '0; frd_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_depth_q <= cfg_data_i;
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + SlotW'(1);
        ST_IDLE: begin
          drop_q <= 1'b0; dup_q <= 1'b0; scan_q <= '0; frd_v_q <= 1'b0;
          tbl_q <= 1'b0; pn_q <= '0;
        end
        ST_HASH: begin
          ppos_q <= hash_slot;
          if (first_q) begin
            pos_q <= '0;
            if (samples_q != '1) samples_q <= samples_q + 32'd1;
            if (addr_q == 64'd0) drop_q <= 1'b1;
          end
        end
        ST_PROBE_CHK: begin
          if (hit || empty_slot) begin
            if (empty_slot && !hit) begin
              if (tbl_q) incl_occ_q <= incl_occ_q + CntW'(1);
              else leaf_occ_q <= leaf_occ_q + CntW'(1);
            end
            if (!tbl_q) begin scan_q <= '0; frd_v_q <= 1'b0; end
          end else if (last_probe) begin
            drop_q <= 1'b1;
            if (!tbl_q) begin scan_q <= '0; frd_v_q <= 1'b0; end
          end else begin
            ppos_q <= ppos_q + SlotW'(1);
            pn_q <= pn_q + CntW'(1);
          end
        end
        ST_DUP_SCAN: begin
          if (take_incl) begin
            // Pipelined read: frd_q holds entry scan_q-1 when frd_v_q.
            if (frd_v_q && frd_q == addr_q) dup_q <= 1'b1;
            if (scan_q < pos_q) begin
              scan_q <= scan_q + DepthW'(1); frd_v_q <= 1'b1;
            end else if (frd_v_q) begin
              frd_v_q <= 1'b0;
            end else begin
              pos_q <= pos_q + DepthW'(1);
              // A zero address is never tallied; it is dropped only when it is not a
              // repeat within the sample.
              if (addr_q == 64'd0 && !dup_q) drop_q <= 1'b1;
              tbl_q <= 1'b1; pn_q <= '0; ppos_q <= hash_slot;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= s_axis_tdata[0]; addr_q <= s_axis_tdata[64:1];
      sel_q <= s_axis_tdata[65]; idx_q <= s_axis_tdata[77:66];
      first_q <= s_axis_tuser;
      ra_q <= 64'd0; rcnt_q <= 32'd0;
    end else if (state_q == ST_READ_WAIT && 32'(idx_q) < TABLE_SLOTS) begin
      ra_q <= rk_q; rcnt_q <= rc_q;
    end
  end

  assign m_axis_tdata = {6'd0, samples_q, 13'(incl_occ_q), 13'(leaf_occ_q), rcnt_q, ra_q};
  assign m_axis_tuser = (op_q == OpRecord) ? drop_q : 1'b0;
endmodule
`default_nettype wire

/* src/sat_checker.sv */
// Port-level checker for the sample address tally block.
// Depends on sample_address_tally, which it binds to.
`default_nettype none
module sat_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [159:0] m_axis_tdata,
  input wire logic         m_axis_tuser
);
  // Never ready for input while a result beat waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
  // A result beat holds while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // An accepted input is not answered in the next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("too fast");
  // A read result never claims a drop: rd fields zero means record or empty.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
    else $error("drop with read data");
endmodule

bind sample_address_tally sat_checker u_sat_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the sample address tally block.
// Predicts every result beat from its own model of both hash tables and
// compares it field by field; depends on sat_pkg and sample_address_tally.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int unsigned Slots  = TableSlotsDef;
  localparam int unsigned DepLim = DepthLimitDef;

  typedef struct packed {
    logic [63:0] rd_addr;
    logic [31:0] rd_count;
    logic [12:0] leaf_in_use;
    logic [12:0] incl_in_use;
    logic [31:0] sample_total;
    logic        dropped;
  } tally_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [5:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         m_axis_tuser;

  sample_address_tally u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: both tables, the current sample and the depth register.
  logic [63:0] leaf_key_q [Slots];
  logic [31:0] leaf_cnt_q [Slots];
  logic [63:0] incl_key_q [Slots];
  logic [31:0] incl_cnt_q [Slots];
  logic [63:0] sample_addr_q [DepLim];
  int unsigned leaf_slots_taken, incl_slots_taken, frame_pos;
  logic [31:0] samples_seen;
  logic [5:0]  depth_reg;

  tally_result_t pending_results [$];
  int unsigned   mismatches;
  bit            quiet_mode;
  logic [63:0]   recent_addrs [$];

  // Inserts or counts one address; returns 0 when it cannot be stored.
  function automatic bit tally_insert(bit incl, logic [63:0] addr);
    logic [63:0] prod;
    int unsigned pos;
    if (addr == 64'd0) return 1'b0;
    prod = (addr >> 2) * 64'd2654435761;
    pos = 32'(prod[11:0]);
    for (int n = 0; n < Slots; n++) begin
      if ((incl ? incl_key_q[pos] : leaf_key_q[pos]) == addr) begin
        if (incl) begin
          if (incl_cnt_q[pos] != 32'hFFFF_FFFF) incl_cnt_q[pos]++;
        end else begin
          if (leaf_cnt_q[pos] != 32'hFFFF_FFFF) leaf_cnt_q[pos]++;
        end
        return 1'b1;
      end
      if ((incl ? incl_key_q[pos] : leaf_key_q[pos]) == 64'd0) begin
        if (incl) begin
          incl_key_q[pos] = addr; incl_cnt_q[pos] = 32'd1; incl_slots_taken++;
        end else begin
          leaf_key_q[pos] = addr; leaf_cnt_q[pos] = 32'd1; leaf_slots_taken++;
        end
        return 1'b1;
      end
      pos = (pos + 1) % Slots;
    end
    return 1'b0;
  endfunction

  // Computes the result beat of one input item and updates the state.
  function automatic tally_result_t predict_tally(logic op, logic [63:0] addr,
                                                  logic first, logic sel,
                                                  logic [11:0] idx);
    tally_result_t r;
    int unsigned depth;
    bit dup;
    r = '0;
    if (op == OpRead) begin
      r.rd_addr  = sel ? incl_key_q[idx] : leaf_key_q[idx];
      r.rd_count = sel ? incl_cnt_q[idx] : leaf_cnt_q[idx];
    end else begin
      depth = 32'(depth_reg);
      if (depth == 0) depth = 1;
      if (depth > DepLim) depth = DepLim;
      if (first) begin
        frame_pos = 0;
        if (samples_seen != 32'hFFFF_FFFF) samples_seen++;
        if (!tally_insert(1'b0, addr)) r.dropped = 1'b1;
      end
      if (frame_pos < depth) begin
        dup = 1'b0;
        for (int k = 0; k < frame_pos; k++)
          if (sample_addr_q[k] == addr) dup = 1'b1;
        if (!dup && !tally_insert(1'b1, addr)) r.dropped = 1'b1;
        sample_addr_q[frame_pos] = addr;
        frame_pos++;
      end
    end
    r.leaf_in_use  = leaf_slots_taken[12:0];
    r.incl_in_use  = incl_slots_taken[12:0];
    r.sample_total = samples_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // Sends one item beat and queues its prediction at the accepting edge.
  task automatic send_item(logic op, logic [63:0] addr, logic first, logic sel,
                           logic [11:0] idx);
    int gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, sel, addr, op};
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_tally(op, addr, first, sel, idx));
    s_axis_tvalid <= 1'b0;
    // The block is busy after it accepts a beat, so the task waits for the
    // clock before the next beat starts.
    @(posedge clk_i);
  endtask

  // Checks each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    tally_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rd_addr      = m_axis_tdata[63:0];
      got.rd_count     = m_axis_tdata[95:64];
      got.leaf_in_use  = m_axis_tdata[108:96];
      got.incl_in_use  = m_axis_tdata[121:109];
      got.sample_total = m_axis_tdata[153:122];
      got.dropped      = m_axis_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", got.rd_addr, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.rd_addr != want.rd_addr)
          report_mismatch("rd_addr", got.rd_addr, want.rd_addr);
        if (got.rd_count != want.rd_count)
          report_mismatch("rd_count", got.rd_count, want.rd_count);
        if (got.leaf_in_use != want.leaf_in_use)
          report_mismatch("leaf_in_use", got.leaf_in_use, want.leaf_in_use);
        if (got.incl_in_use != want.incl_in_use)
          report_mismatch("incl_in_use", got.incl_in_use, want.incl_in_use);
        if (got.sample_total != want.sample_total)
          report_mismatch("sample_total", got.sample_total, want.sample_total);
        if (got.dropped != want.dropped)
          report_mismatch("dropped", got.dropped, want.dropped);
      end
    end
  end

  // Receiver stalls in random bursts, none in quiet mode.
  always @(posedge clk_i) begin
    int burst;
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 12);
      m_axis_tready <= 1'b0;
      repeat (burst) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [5:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    depth_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Picks an address, often one seen before so that counts build up.
  function automatic logic [63:0] pick_addr();
    logic [63:0] a;
    if (recent_addrs.size() != 0 && $urandom_range(0, 2) != 0)
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    a = {$urandom(), $urandom()};
    if ($urandom_range(0, 1)) a = {48'h0, a[15:0]};
    if ($urandom_range(0, 40) == 0) a = 64'd0;
    recent_addrs.push_back(a);
    if (recent_addrs.size() > 64) void'(recent_addrs.pop_front());
    return a;
  endfunction

  // Reads a random slot of a randomly chosen table.
  task automatic read_random_slot();
    send_item(OpRead, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 12'($urandom_range(0, Slots - 1)));
  endtask

  task automatic test_directed();
    send_item(OpRecord, 64'h1234, 1'b0, 1'b0, 12'd0);        // frame before any sample
    send_item(OpRecord, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 12'hFFF);
    send_item(OpRecord, 64'd0, 1'b0, 1'b0, 12'd0);           // zero address
    send_item(OpRecord, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 12'd0); // duplicate
    send_item(OpRecord, 64'd0, 1'b0, 1'b0, 12'd0);           // repeated zero address
    send_item(OpRecord, 64'd0, 1'b1, 1'b0, 12'd0);           // zero leaf
    send_item(OpRecord, 64'h8000_0000_0000_0004, 1'b0, 1'b0, 12'd0);
    for (int i = 0; i < 9; i++)                              // past depth
      send_item(OpRecord, 64'h100 + 64'(4 * i), 1'b0, 1'b0, 12'd0);
    send_item(OpRecord, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 12'd0);
    send_item(OpRead, 64'd0, 1'b0, 1'b0, 12'd0);
    send_item(OpRead, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 12'hFFF);
    for (int i = 0; i < 4; i++) read_random_slot();
  endtask

  task automatic test_random(int items);
    int len;
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 8) begin
        // Well-formed sample: leaf then callers.
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_item(OpRecord, pick_addr(), i == 0,
                                                 1'($urandom_range(0, 1)),
                                                 12'($urandom()));
        sent += len;
      end else begin
        if ($urandom_range(0, 1)) read_random_slot();
        else send_item(OpRecord, pick_addr(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 12'($urandom()));
        sent++;
      end
    end
  endtask

  // Leaves whose hashes all land on one slot build a long probe chain.
  task automatic test_collisions();
    for (int i = 1; i <= 24; i++)
      send_item(OpRecord, 64'h7000_0000 + 64'(i) * 64'h4000, 1'b1, 1'b0, 12'd0);
    send_item(OpRecord, 64'h7000_4000, 1'b1, 1'b0, 12'd0);
    for (int i = 0; i < 4; i++) read_random_slot();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      leaf_key_q[i] = '0; leaf_cnt_q[i] = '0; incl_key_q[i] = '0; incl_cnt_q[i] = '0;
    end
    leaf_slots_taken = 0; incl_slots_taken = 0; frame_pos = 0; samples_seen = '0;
    depth_reg = MaxDepthReset; mismatches = 0; quiet_mode = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_depth(6'd1);
    test_random(250);
    write_depth(6'd0);
    test_random(150);
    write_depth(6'd32);
    test_random(300);
    write_depth(6'd63);
    test_random(200);
    drain_results();                 // sender holds until all results are in
    write_depth(6'd5);
    test_random(250);
    quiet_mode = 1'b1;
    write_depth(MaxDepthReset);
    test_random(250);
    test_collisions();
    drain_results();

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
